@@ design/dcps_pkg.sv @@
// ----------------------------------------------------------------------------
// dcps_pkg: shared types and constants of the dma channel program sequencer
// holds the write descriptor, step codes, mode bits and page port table
// ----------------------------------------------------------------------------
package dcps_pkg;

	localparam int unsigned PortW  = 10;
	localparam int unsigned AddrW  = 24;
	localparam int unsigned CountW = 18;
	localparam int unsigned ChanW  = 3;

	localparam int unsigned QueueDepthDefault = 2;

	// configuration register indexes
	localparam logic CFG_LOW_BASE  = 1'b0;
	localparam logic CFG_HIGH_BASE = 1'b1;

	localparam logic [PortW-1:0] LOW_BASE_RESET  = 10'd0;
	localparam logic [PortW-1:0] HIGH_BASE_RESET = 10'd192;

	// 8237 mode register bits
	localparam logic [7:0] MODE_SINGLE  = 8'h40;
	localparam logic [7:0] MODE_WRITE   = 8'h04;
	localparam logic [7:0] MODE_READ    = 8'h08;
	localparam logic [7:0] MODE_CASCADE = 8'hC0;

	// register offsets in units of the port stride
	localparam logic [PortW-1:0] OFF_MASK = 10'd10;
	localparam logic [PortW-1:0] OFF_MODE = 10'd11;
	localparam logic [PortW-1:0] OFF_FFC  = 10'd12;

	localparam logic [CountW-1:0] BYTE_LIMIT = 18'h10000;
	localparam logic [CountW-1:0] WORD_LIMIT = 18'h20000;

	// step of the programming sequence
	typedef logic [2:0] step_t;
	localparam step_t STEP_MODE   = 3'd0;
	localparam step_t STEP_FFC    = 3'd1;
	localparam step_t STEP_ADDR_L = 3'd2;
	localparam step_t STEP_ADDR_H = 3'd3;
	localparam step_t STEP_PAGE   = 3'd4;
	localparam step_t STEP_CNT_L  = 3'd5;
	localparam step_t STEP_CNT_H  = 3'd6;
	localparam step_t STEP_MASK   = 3'd7;

	// one classified request, ready to be played out
	typedef struct packed {
		logic             error;
		logic             cascade;
		logic [7:0]       mode_byte;
		logic [7:0]       mask_byte;
		logic [15:0]      addr;
		logic [7:0]       page;
		logic [15:0]      cnt;
		logic [PortW-1:0] mode_port;
		logic [PortW-1:0] ffc_port;
		logic [PortW-1:0] addr_port;
		logic [PortW-1:0] cnt_port;
		logic [PortW-1:0] page_port;
		logic [PortW-1:0] mask_port;
	} desc_t;

	function automatic logic [PortW-1:0] page_port_of(input logic [ChanW-1:0] chan);
		logic [PortW-1:0] p;
		case (chan)
			3'd0:    p = 10'h087;
			3'd1:    p = 10'h083;
			3'd2:    p = 10'h081;
			3'd3:    p = 10'h082;
			3'd4:    p = 10'h08F;
			3'd5:    p = 10'h08B;
			3'd6:    p = 10'h089;
			3'd7:    p = 10'h08A;
			default: p = 10'h087;
		endcase
		return p;
	endfunction

endpackage

@@ design/dcps_if.sv @@
// ----------------------------------------------------------------------------
// dcps_if: request and port write channels
// valid/ready channels carrying set-up requests and port writes
// ----------------------------------------------------------------------------
interface dcps_req_if;
	logic                          valid;
	logic                          ready;
	logic                          mode;
	logic                          to_memory;
	logic [dcps_pkg::AddrW-1:0]    phys_addr;
	logic [dcps_pkg::CountW-1:0]   byte_count;
	logic [dcps_pkg::ChanW-1:0]    channel;

	modport source (output valid, output mode, output to_memory, output phys_addr,
		output byte_count, output channel, input ready);
	modport sink (input valid, input mode, input to_memory, input phys_addr,
		input byte_count, input channel, output ready);
endinterface

interface dcps_wr_if;
	logic                          valid;
	logic                          ready;
	logic [dcps_pkg::PortW-1:0]    port;
	logic [7:0]                    data;
	logic                          error;
	logic                          last;

	modport source (output valid, output port, output data, output error, output last,
		input ready);
	modport sink (input valid, input port, input data, input error, input last,
		output ready);
endinterface

@@ design/dma_channel_program_sequencer.sv @@
// ----------------------------------------------------------------------------
// dma_channel_program_sequencer: 8237 channel programming sequencer
// turns one dma set-up request into the port writes that program the channel
// ----------------------------------------------------------------------------
// Each transfer on req is one set-up request for channel 0..7 of a cascaded
// pair of 8237 controllers; each transfer on wr is one i/o port write. A
// normal request gives eight writes (mode, flip-flop clear, address low and
// high, page, count low and high, unmask), a cascade request gives two (mode,
// unmask) and an impossible request (count too large, or an odd address on a
// word channel) gives a single write flagged error with port and data zero.
// last marks the final write of each answer. Channels 4..7 use the high
// controller with port stride two, halved address and halved count. The wr
// channel carries one write per cycle while wr.ready is high; that output
// sequencer is the limit on throughput. The request side classifies in the
// accept cycle and lands in a short queue, so req keeps taking requests
// while writes are still going out and the queue has room; the first write
// is held in the queue and then in the output register. The controller
// bases are written through cfg_we/cfg_index/cfg_wdata (index 0 low base,
// 1 high base) and must only change while no request is in flight.
module dma_channel_program_sequencer #(
	parameter int unsigned QueueDepth = dcps_pkg::QueueDepthDefault
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [dcps_pkg::PortW-1:0] cfg_wdata,
	dcps_req_if.sink                   req,
	dcps_wr_if.source                  wr
);

	// controller base registers
	logic [dcps_pkg::PortW-1:0] low_base_q;
	logic [dcps_pkg::PortW-1:0] high_base_q;

	// classified request heading for the queue
	dcps_pkg::desc_t in_desc;
	dcps_pkg::desc_t head_desc;
	logic            queue_full;
	logic            head_valid;
	logic            pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_base_q  <= dcps_pkg::LOW_BASE_RESET;
			high_base_q <= dcps_pkg::HIGH_BASE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				dcps_pkg::CFG_LOW_BASE:  low_base_q  <= cfg_wdata;
				dcps_pkg::CFG_HIGH_BASE: high_base_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// front: work out the whole write sequence as the request is taken
	dcps_front u_front (
		.mode       (req.mode),
		.to_memory  (req.to_memory),
		.phys_addr  (req.phys_addr),
		.byte_count (req.byte_count),
		.channel    (req.channel),
		.low_base   (low_base_q),
		.high_base  (high_base_q),
		.desc       (in_desc)
	);

	// a request is taken whenever the queue has room
	assign req.ready = !queue_full;

	dcps_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (req.valid),
		.push_desc  (in_desc),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_desc  (head_desc)
	);

	// back: one port write per cycle from the head of the queue while wr.ready allows
	dcps_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_desc  (head_desc),
		.pop        (pop),
		.out_ready  (wr.ready),
		.out_valid  (wr.valid),
		.out_port   (wr.port),
		.out_data   (wr.data),
		.out_error  (wr.error),
		.out_last   (wr.last)
	);

endmodule

@@ design/dcps_front.sv @@
// ----------------------------------------------------------------------------
// dcps_front: request classifier
// checks a request and works out every port and byte of its sequence
// ----------------------------------------------------------------------------
module dcps_front (
	input  logic                           mode,
	input  logic                           to_memory,
	input  logic [dcps_pkg::AddrW-1:0]     phys_addr,
	input  logic [dcps_pkg::CountW-1:0]    byte_count,
	input  logic [dcps_pkg::ChanW-1:0]     channel,
	input  logic [dcps_pkg::PortW-1:0]     low_base,
	input  logic [dcps_pkg::PortW-1:0]     high_base,
	output dcps_pkg::desc_t                desc
);

	logic                          word;
	logic [1:0]                    c;
	logic [dcps_pkg::PortW-1:0]    base;
	logic [dcps_pkg::PortW-1:0]    stride;
	logic [dcps_pkg::PortW-1:0]    addr_port;
	logic [dcps_pkg::CountW-1:0]   cnt_full;
	logic [dcps_pkg::AddrW-1:0]    a;
	logic                          too_big;

	always_comb begin
		word      = channel[2];
		c         = channel[1:0];
		base      = word ? high_base : low_base;
		stride    = word ? 10'd2 : 10'd1;
		addr_port = base + ((word ? 10'd4 : 10'd2) * {8'd0, c});
		a         = word ? {1'b0, phys_addr[dcps_pkg::AddrW-1:1]} : phys_addr;
		cnt_full  = (word ? {1'b0, byte_count[dcps_pkg::CountW-1:1]} : byte_count) - 18'd1;
		too_big   = word ? (byte_count > dcps_pkg::WORD_LIMIT || phys_addr[0])
		                 : (byte_count > dcps_pkg::BYTE_LIMIT);

		desc.cascade   = mode;
		desc.error     = !mode && too_big;
		desc.mode_byte = mode ? (dcps_pkg::MODE_CASCADE | {6'd0, c})
		                      : (dcps_pkg::MODE_SINGLE | {6'd0, c} |
		                         (to_memory ? dcps_pkg::MODE_WRITE : dcps_pkg::MODE_READ));
		desc.mask_byte = {6'd0, c};
		desc.addr      = a[15:0];
		desc.page      = phys_addr[23:16];
		desc.cnt       = cnt_full[15:0];
		desc.mode_port = base + stride * dcps_pkg::OFF_MODE;
		desc.ffc_port  = base + stride * dcps_pkg::OFF_FFC;
		desc.mask_port = base + stride * dcps_pkg::OFF_MASK;
		desc.addr_port = addr_port;
		desc.cnt_port  = addr_port + stride;
		desc.page_port = dcps_pkg::page_port_of(channel);
	end

endmodule

@@ design/dcps_queue.sv @@
// ----------------------------------------------------------------------------
// dcps_queue: descriptor queue
// short first-in first-out store between the classifier and the sequencer
// ----------------------------------------------------------------------------
module dcps_queue #(
	parameter int unsigned Depth = dcps_pkg::QueueDepthDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dcps_pkg::desc_t push_desc,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output dcps_pkg::desc_t head_desc
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrLast  = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] CntDepth = CntW'(Depth);

	dcps_pkg::desc_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full       = (count_q == CntDepth);
	assign head_valid = (count_q != '0);
	assign head_desc  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ design/dcps_back.sv @@
// ----------------------------------------------------------------------------
// dcps_back: port write sequencer
// steps through the head descriptor and drives one port write per transfer
// ----------------------------------------------------------------------------
module dcps_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        head_valid,
	input  dcps_pkg::desc_t             head_desc,
	output logic                        pop,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [dcps_pkg::PortW-1:0]  out_port,
	output logic [7:0]                  out_data,
	output logic                        out_error,
	output logic                        out_last
);

	dcps_pkg::step_t            step_q;
	dcps_pkg::step_t            step_next;
	logic                       valid_q;
	logic [dcps_pkg::PortW-1:0] port_q;
	logic [7:0]                 data_q;
	logic                       error_q;
	logic                       last_q;
	logic                       load;
	logic [dcps_pkg::PortW-1:0] cur_port;
	logic [7:0]                 cur_data;
	logic                       cur_last;

	always_comb begin
		case (step_q)
			dcps_pkg::STEP_MODE: begin
				cur_port = head_desc.mode_port;
				cur_data = head_desc.mode_byte;
			end
			dcps_pkg::STEP_FFC: begin
				cur_port = head_desc.ffc_port;
				cur_data = 8'd0;
			end
			dcps_pkg::STEP_ADDR_L: begin
				cur_port = head_desc.addr_port;
				cur_data = head_desc.addr[7:0];
			end
			dcps_pkg::STEP_ADDR_H: begin
				cur_port = head_desc.addr_port;
				cur_data = head_desc.addr[15:8];
			end
			dcps_pkg::STEP_PAGE: begin
				cur_port = head_desc.page_port;
				cur_data = head_desc.page;
			end
			dcps_pkg::STEP_CNT_L: begin
				cur_port = head_desc.cnt_port;
				cur_data = head_desc.cnt[7:0];
			end
			dcps_pkg::STEP_CNT_H: begin
				cur_port = head_desc.cnt_port;
				cur_data = head_desc.cnt[15:8];
			end
			dcps_pkg::STEP_MASK: begin
				cur_port = head_desc.mask_port;
				cur_data = head_desc.mask_byte;
			end
			default: begin
				cur_port = head_desc.mode_port;
				cur_data = head_desc.mode_byte;
			end
		endcase
		// an impossible request answers with a single blank write
		if (head_desc.error) begin
			cur_port = '0;
			cur_data = 8'd0;
		end
		cur_last = head_desc.error || (step_q == dcps_pkg::STEP_MASK);
		if (cur_last) begin
			step_next = dcps_pkg::STEP_MODE;
		end else if (head_desc.cascade) begin
			step_next = dcps_pkg::STEP_MASK;
		end else begin
			step_next = step_q + 3'd1;
		end
	end

	assign load = head_valid && (!valid_q || out_ready);
	assign pop  = load && cur_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			step_q  <= dcps_pkg::STEP_MODE;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				step_q  <= step_next;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			port_q  <= cur_port;
			data_q  <= cur_data;
			error_q <= head_desc.error;
			last_q  <= cur_last;
		end
	end

	assign out_valid = valid_q;
	assign out_port  = port_q;
	assign out_data  = data_q;
	assign out_error = error_q;
	assign out_last  = last_q;

endmodule
